[hdl/hlcc_pkg.sv]
// Package for the hex lattice cell classifier: widths, constants, codes,
// shared structs and the divider-step and cube-round functions.
// No dependencies.
package hlcc_pkg;

	localparam int FRAC = 16;
	localparam int CW = 10;
	localparam int PXW = 12;
	localparam int PYW = 13;
	localparam int NUMW = 48;
	localparam int DVW = 30;
	localparam int DSW = 8;
	localparam int PW = DSW + 1 + DVW;
	localparam int DIV_STAGES = DVW;
	localparam int FRONT_STAGES = 3;
	localparam int BACK_STAGES = 7;
	localparam int TOTAL_STAGES = FRONT_STAGES + DIV_STAGES + BACK_STAGES;
	localparam int FW = 32;
	localparam int HW = 16;
	localparam int OW = 10;
	localparam int DXW = 25;
	localparam int AW = 24;
	localparam int MW = 24;
	localparam int CYW = 58;
	localparam int DYW = 42;
	localparam int BW = 41;
	localparam int CMPW = 52;
	localparam int LIMW = 18;

	localparam logic [32:0] SQRT3_Q32 = 33'd7439101574;
	localparam logic [22:0] TAN22_Q24 = 23'd6949350;
	localparam logic [25:0] TAN67_Q24 = 26'd40503782;

	typedef enum logic [1:0] {
		GLYPH_DASH   = 2'd0,
		GLYPH_BSLASH = 2'd1,
		GLYPH_BAR    = 2'd2,
		GLYPH_SLASH  = 2'd3
	} glyph_t;

	typedef enum logic [2:0] {
		REG_HEX_SIZE     = 3'd0,
		REG_BORDER_WIDTH = 3'd1,
		REG_ORIGIN_COL   = 3'd2,
		REG_ORIGIN_ROW   = 3'd3,
		REG_CURSOR_Q     = 3'd4,
		REG_CURSOR_R     = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [5:0]             size;
		logic [DSW-1:0]         dvs;
		logic [7:0]             border;
		logic [CW-1:0]          ocol;
		logic [CW-1:0]          orow;
		logic signed [HW-1:0]   cur_q;
		logic signed [HW-1:0]   cur_r;
	} cfg_t;

	typedef struct packed {
		logic signed [PXW-1:0] px;
		logic signed [PYW-1:0] py;
		logic                  sq;
		logic                  sr;
	} side_t;

	typedef struct packed {
		logic signed [HW-1:0] k;
		logic [FRAC:0]        dev;
	} rnd_t;

	// one restoring step: remainder in the upper field, quotient shifts in below
	function automatic logic [PW-1:0] div_step(input logic [PW-1:0] p, input logic [DSW-1:0] d);
		logic [PW-1:0] t;
		logic [DSW:0]  hi;
		t = {p[PW-2:0], 1'b0};
		hi = t[PW-1:DVW];
		if (hi >= {1'b0, d}) begin
			t[PW-1:DVW] = hi - {1'b0, d};
			t[0] = 1'b1;
		end
		return t;
	endfunction

	// round Q.F to integer, ties away from zero, with distance to it
	function automatic rnd_t cube_rnd(input logic signed [FW-1:0] f);
		logic [FW-1:0]       m;
		logic [FW-1:0]       k;
		logic signed [FW:0]  e;
		rnd_t                o;
		m = f[FW-1] ? FW'(-f) : FW'(f);
		k = (m + (FW'(1) << (FRAC - 1))) >> FRAC;
		e = $signed({1'b0, FW'(k << FRAC)}) - $signed({1'b0, m});
		o.dev = (FRAC + 1)'(e[FW] ? -e : e);
		o.k = f[FW-1] ? -HW'(k) : HW'(k);
		return o;
	endfunction

endpackage

[hdl/hlcc_div.sv]
// Pipelined restoring divider, one quotient bit per stage.
// Depends on hlcc_pkg.
module hlcc_div (
	input  logic                         clk,
	input  logic                         en,
	input  logic [hlcc_pkg::DVW-1:0]     dvd,
	input  logic [hlcc_pkg::DSW-1:0]     dvs,
	output logic [hlcc_pkg::DVW-1:0]     quo
);

	logic [hlcc_pkg::PW-1:0] p_s [hlcc_pkg::DIV_STAGES];

	always_ff @(posedge clk) begin
		if (en) begin
			p_s[0] <= hlcc_pkg::div_step({{(hlcc_pkg::DSW + 1){1'b0}}, dvd}, dvs);
		end
	end

	for (genvar i = 1; i < hlcc_pkg::DIV_STAGES; i++) begin : g_stage
		always_ff @(posedge clk) begin
			if (en) begin
				p_s[i] <= hlcc_pkg::div_step(p_s[i-1], dvs);
			end
		end
	end

	assign quo = p_s[hlcc_pkg::DIV_STAGES-1][hlcc_pkg::DVW-1:0];

endmodule

[hdl/hlcc_front.sv]
// Front stages: pixel offsets, cube numerators, rounded dividends for the divider.
// Depends on hlcc_pkg.
module hlcc_front (
	input  logic                          clk,
	input  logic                          en,
	input  hlcc_pkg::cfg_t                cfg,
	input  logic [hlcc_pkg::CW-1:0]       cell_col,
	input  logic [hlcc_pkg::CW-1:0]       cell_row,
	output hlcc_pkg::side_t               side,
	output logic [hlcc_pkg::DVW-1:0]      dvq,
	output logic [hlcc_pkg::DVW-1:0]      dvr
);

	logic signed [hlcc_pkg::CW:0]     dc_c, dr_c;
	logic signed [hlcc_pkg::PXW-1:0]  px_s1, px_s2;
	logic signed [hlcc_pkg::PYW-1:0]  py_s1, py_s2;
	logic signed [hlcc_pkg::NUMW-1:0] sq3_c, pyx_c, prod_c, nr_c, nr_s2;
	logic [hlcc_pkg::NUMW-1:0]        mag_r_c, mag_q_c, half_c, xr_c, xq_c;
	logic [hlcc_pkg::PXW-1:0]         apx_c;

	always_comb begin
		dc_c = $signed({1'b0, cell_col}) - $signed({1'b0, cfg.ocol});
		dr_c = $signed({1'b0, cell_row}) - $signed({1'b0, cfg.orow});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s1 <= {dc_c, 1'b0};
			py_s1 <= {dr_c, 2'b00};
		end
	end

	// fr numerator: -px*2^32 + sqrt3*py
	always_comb begin
		sq3_c = $signed({{(hlcc_pkg::NUMW - 33){1'b0}}, hlcc_pkg::SQRT3_Q32});
		pyx_c = hlcc_pkg::NUMW'(py_s1);
		prod_c = sq3_c * pyx_c;
		nr_c = prod_c - (hlcc_pkg::NUMW'(px_s1) <<< 32);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nr_s2 <= nr_c;
			px_s2 <= px_s1;
			py_s2 <= py_s1;
		end
	end

	// |n| + den/2, then drop the 2^16 of den
	always_comb begin
		half_c = hlcc_pkg::NUMW'(cfg.dvs) << (hlcc_pkg::FRAC - 1);
		mag_r_c = nr_s2[hlcc_pkg::NUMW-1] ? hlcc_pkg::NUMW'(-nr_s2) : hlcc_pkg::NUMW'(nr_s2);
		apx_c = px_s2[hlcc_pkg::PXW-1] ? hlcc_pkg::PXW'(-px_s2) : hlcc_pkg::PXW'(px_s2);
		mag_q_c = hlcc_pkg::NUMW'(apx_c) << 33;
		xr_c = mag_r_c + half_c;
		xq_c = mag_q_c + half_c;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dvq <= xq_c[hlcc_pkg::FRAC+hlcc_pkg::DVW-1:hlcc_pkg::FRAC];
			dvr <= xr_c[hlcc_pkg::FRAC+hlcc_pkg::DVW-1:hlcc_pkg::FRAC];
			side.px <= px_s2;
			side.py <= py_s2;
			side.sq <= px_s2[hlcc_pkg::PXW-1];
			side.sr <= nr_s2[hlcc_pkg::NUMW-1];
		end
	end

endmodule

[hdl/hlcc_back.sv]
// Back stages: signed cube coordinates, cube round, edge test, glyph direction.
// Depends on hlcc_pkg.
module hlcc_back (
	input  logic                          clk,
	input  logic                          en,
	input  hlcc_pkg::cfg_t                cfg,
	input  hlcc_pkg::side_t               side,
	input  logic [hlcc_pkg::DVW-1:0]      quo_q,
	input  logic [hlcc_pkg::DVW-1:0]      quo_r,
	output logic                          is_edge,
	output logic [1:0]                    glyph_code,
	output logic                          on_cursor,
	output logic signed [hlcc_pkg::OW-1:0] hex_q,
	output logic signed [hlcc_pkg::OW-1:0] hex_r
);

	// B1
	logic signed [hlcc_pkg::FW-1:0]   fq_c, fr_c;
	logic signed [hlcc_pkg::FW-1:0]   fq_s1, fr_s1, fs_s1;
	logic signed [hlcc_pkg::PXW-1:0]  px_s1, px_s2, px_s3;
	logic signed [hlcc_pkg::PYW-1:0]  py_s1, py_s2, py_s3, py_s4, py_s5;
	// B2
	hlcc_pkg::rnd_t                   rq_c, rr_c, rs_c;
	hlcc_pkg::rnd_t                   rq_s2, rr_s2, rs_s2;
	logic signed [hlcc_pkg::FW-1:0]   fq_s2, fr_s2, fs_s2;
	// B3
	logic signed [hlcc_pkg::HW-1:0]   q_c, r_c, q_s3, r_s3, q_s4, r_s4;
	logic signed [hlcc_pkg::FW-1:0]   fq_s3, fr_s3, fs_s3;
	// B4
	logic signed [hlcc_pkg::FW:0]     eq_c, er_c, es_c;
	logic [hlcc_pkg::FW:0]            aq_c, ar_c, as_c, d_c;
	logic signed [hlcc_pkg::HW-1:0]   s_c;
	logic signed [hlcc_pkg::LIMW-1:0] lim_c;
	logic signed [hlcc_pkg::DXW-1:0]  dxn_c, dxn_s4;
	logic signed [hlcc_pkg::MW-1:0]   m_c, m_s4;
	logic signed [hlcc_pkg::HW+1:0]   qr2_c;
	logic                             edge_s4, edge_s5, edge_s6;
	logic                             cur_s4, cur_s5, cur_s6;
	logic signed [hlcc_pkg::HW-1:0]   q_s5, r_s5, q_s6, r_s6;
	// B5
	logic [hlcc_pkg::AW-1:0]          a_c;
	logic signed [hlcc_pkg::CYW-1:0]  cy_s5;
	logic [hlcc_pkg::CMPW-1:0]        a22_s5, a67_s5, a22_s6, a67_s6;
	logic                             sdx_s5, sdx_s6;
	// B6
	logic [hlcc_pkg::CYW-1:0]         cym_c;
	logic [hlcc_pkg::CYW-1:0]         cyk_c;
	logic signed [hlcc_pkg::DYW-1:0]  cyq_c, dy_c;
	logic [hlcc_pkg::BW-1:0]          b_s6;
	logic                             sdy_s6;
	// B7
	logic [hlcc_pkg::CMPW-1:0]        bs_c;
	hlcc_pkg::glyph_t                 glyph_c;

	always_comb begin
		fq_c = side.sq ? -hlcc_pkg::FW'(quo_q) : hlcc_pkg::FW'(quo_q);
		fr_c = side.sr ? -hlcc_pkg::FW'(quo_r) : hlcc_pkg::FW'(quo_r);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fq_s1 <= fq_c;
			fr_s1 <= fr_c;
			fs_s1 <= -fq_c - fr_c;
			px_s1 <= side.px;
			py_s1 <= side.py;
		end
	end

	always_comb begin
		rq_c = hlcc_pkg::cube_rnd(fq_s1);
		rr_c = hlcc_pkg::cube_rnd(fr_s1);
		rs_c = hlcc_pkg::cube_rnd(fs_s1);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rq_s2 <= rq_c;
			rr_s2 <= rr_c;
			rs_s2 <= rs_c;
			fq_s2 <= fq_s1;
			fr_s2 <= fr_s1;
			fs_s2 <= fs_s1;
			px_s2 <= px_s1;
			py_s2 <= py_s1;
		end
	end

	always_comb begin
		if (rq_s2.dev > rr_s2.dev && rq_s2.dev > rs_s2.dev) begin
			q_c = -rr_s2.k - rs_s2.k;
			r_c = rr_s2.k;
		end else if (rr_s2.dev > rs_s2.dev) begin
			q_c = rq_s2.k;
			r_c = -rq_s2.k - rs_s2.k;
		end else begin
			q_c = rq_s2.k;
			r_c = rr_s2.k;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q_s3 <= q_c;
			r_s3 <= r_c;
			fq_s3 <= fq_s2;
			fr_s3 <= fr_s2;
			fs_s3 <= fs_s2;
			px_s3 <= px_s2;
			py_s3 <= py_s2;
		end
	end

	// edge distance, cursor match, centre offset terms
	always_comb begin
		s_c = -q_s3 - r_s3;
		eq_c = (hlcc_pkg::FW + 1)'(fq_s3) - ((hlcc_pkg::FW + 1)'(q_s3) <<< hlcc_pkg::FRAC);
		er_c = (hlcc_pkg::FW + 1)'(fr_s3) - ((hlcc_pkg::FW + 1)'(r_s3) <<< hlcc_pkg::FRAC);
		es_c = (hlcc_pkg::FW + 1)'(fs_s3) - ((hlcc_pkg::FW + 1)'(s_c) <<< hlcc_pkg::FRAC);
		aq_c = eq_c[hlcc_pkg::FW] ? (hlcc_pkg::FW + 1)'(-eq_c) : (hlcc_pkg::FW + 1)'(eq_c);
		ar_c = er_c[hlcc_pkg::FW] ? (hlcc_pkg::FW + 1)'(-er_c) : (hlcc_pkg::FW + 1)'(er_c);
		as_c = es_c[hlcc_pkg::FW] ? (hlcc_pkg::FW + 1)'(-es_c) : (hlcc_pkg::FW + 1)'(es_c);
		d_c = aq_c;
		if (ar_c > d_c) begin
			d_c = ar_c;
		end
		if (as_c > d_c) begin
			d_c = as_c;
		end
		lim_c = (hlcc_pkg::LIMW'(1) <<< (hlcc_pkg::FRAC - 1))
			- (hlcc_pkg::LIMW'({1'b0, cfg.border}) <<< (hlcc_pkg::FRAC - 8));
		dxn_c = (hlcc_pkg::DXW'(px_s3) <<< 1)
			- hlcc_pkg::DXW'($signed({1'b0, cfg.dvs}) * q_s3);
		qr2_c = (hlcc_pkg::HW + 2)'(q_s3) + ((hlcc_pkg::HW + 2)'(r_s3) <<< 1);
		m_c = hlcc_pkg::MW'($signed({1'b0, cfg.size}) * qr2_c);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			edge_s4 <= $signed({1'b0, d_c}) >= (hlcc_pkg::FW + 2)'(lim_c);
			cur_s4 <= (q_s3 == cfg.cur_q) && (r_s3 == cfg.cur_r);
			dxn_s4 <= dxn_c;
			m_s4 <= m_c;
			q_s4 <= q_s3;
			r_s4 <= r_s3;
			py_s4 <= py_s3;
		end
	end

	always_comb begin
		a_c = dxn_s4[hlcc_pkg::DXW-1] ? hlcc_pkg::AW'(-dxn_s4) : hlcc_pkg::AW'(dxn_s4);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cy_s5 <= hlcc_pkg::CYW'(m_s4) * $signed({1'b0, hlcc_pkg::SQRT3_Q32});
			a22_s5 <= hlcc_pkg::CMPW'(a_c) * hlcc_pkg::CMPW'(hlcc_pkg::TAN22_Q24);
			a67_s5 <= hlcc_pkg::CMPW'(a_c) * hlcc_pkg::CMPW'(hlcc_pkg::TAN67_Q24);
			sdx_s5 <= dxn_s4[hlcc_pkg::DXW-1];
			edge_s5 <= edge_s4;
			cur_s5 <= cur_s4;
			q_s5 <= q_s4;
			r_s5 <= r_s4;
			py_s5 <= py_s4;
		end
	end

	// centre y rounded from Q33 to Q.F
	always_comb begin
		cym_c = cy_s5[hlcc_pkg::CYW-1] ? hlcc_pkg::CYW'(-cy_s5) : hlcc_pkg::CYW'(cy_s5);
		cyk_c = (cym_c + (hlcc_pkg::CYW'(1) << (32 - hlcc_pkg::FRAC)))
			>> (33 - hlcc_pkg::FRAC);
		cyq_c = cy_s5[hlcc_pkg::CYW-1] ? -hlcc_pkg::DYW'(cyk_c) : hlcc_pkg::DYW'(cyk_c);
		dy_c = (hlcc_pkg::DYW'(py_s5) <<< hlcc_pkg::FRAC) - cyq_c;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			b_s6 <= dy_c[hlcc_pkg::DYW-1] ? hlcc_pkg::BW'(-dy_c) : hlcc_pkg::BW'(dy_c);
			sdy_s6 <= dy_c[hlcc_pkg::DYW-1];
			sdx_s6 <= sdx_s5;
			a22_s6 <= a22_s5;
			a67_s6 <= a67_s5;
			edge_s6 <= edge_s5;
			cur_s6 <= cur_s5;
			q_s6 <= q_s5;
			r_s6 <= r_s5;
		end
	end

	// dx carries a 2^15 factor, so b*2^24 vs a*tan becomes b*2^9
	always_comb begin
		bs_c = hlcc_pkg::CMPW'(b_s6) << 9;
		if (!edge_s6) begin
			glyph_c = hlcc_pkg::GLYPH_DASH;
		end else if (bs_c <= a22_s6) begin
			glyph_c = hlcc_pkg::GLYPH_BAR;
		end else if (bs_c >= a67_s6) begin
			glyph_c = hlcc_pkg::GLYPH_DASH;
		end else if (sdx_s6 == sdy_s6) begin
			glyph_c = hlcc_pkg::GLYPH_SLASH;
		end else begin
			glyph_c = hlcc_pkg::GLYPH_BSLASH;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			is_edge <= edge_s6;
			glyph_code <= glyph_c;
			on_cursor <= cur_s6;
			hex_q <= q_s6[hlcc_pkg::OW-1:0];
			hex_r <= r_s6[hlcc_pkg::OW-1:0];
		end
	end

endmodule

[hdl/hex_lattice_cell_classifier.sv]
// Top level of the hex lattice cell classifier: config registers, valid chain,
// stall control. Depends on hlcc_pkg, hlcc_front, hlcc_div, hlcc_back.
//
//  channel  | handshake              | word
//  ---------+------------------------+--------------------------------------------
//  in       | in_valid / in_stall    | cell_col, cell_row
//  out      | out_valid / out_stall  | is_edge, glyph_code, on_cursor, hex_q, hex_r
//  config   | cfg_we                 | cfg_index, cfg_data
//
// One word per clock when not stalled; 3 front stages, 30 divider stages
// (one quotient bit each, two lanes), 7 back stages ending in the output register.
// The whole pipe advances together; out_stall on a valid output word holds every
// stage and raises in_stall in the same cycle.
// Reset clears the valid chain and loads the config registers; no clearing pass.
module hex_lattice_cell_classifier (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [2:0]                      cfg_index,
	input  logic [15:0]                     cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [hlcc_pkg::CW-1:0]         cell_col,
	input  logic [hlcc_pkg::CW-1:0]         cell_row,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            is_edge,
	output logic [1:0]                      glyph_code,
	output logic                            on_cursor,
	output logic signed [hlcc_pkg::OW-1:0]  hex_q,
	output logic signed [hlcc_pkg::OW-1:0]  hex_r
);

	logic [5:0]                        size_q;
	logic [7:0]                        border_q;
	logic [hlcc_pkg::CW-1:0]           ocol_q, orow_q;
	logic signed [hlcc_pkg::HW-1:0]    curq_q, curr_q;
	logic [5:0]                        size_c;
	hlcc_pkg::cfg_t                    cfg;
	logic                              en;
	logic [hlcc_pkg::TOTAL_STAGES-1:0] vld_s;
	hlcc_pkg::side_t                   side_f;
	hlcc_pkg::side_t                   sd_s [hlcc_pkg::DIV_STAGES];
	logic [hlcc_pkg::DVW-1:0]          dvq, dvr, quo_q, quo_r;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= 6'd14;
			border_q <= 8'd26;
			ocol_q <= '0;
			orow_q <= '0;
			curq_q <= '0;
			curr_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				hlcc_pkg::REG_HEX_SIZE:     size_q <= cfg_data[5:0];
				hlcc_pkg::REG_BORDER_WIDTH: border_q <= cfg_data[7:0];
				hlcc_pkg::REG_ORIGIN_COL:   ocol_q <= cfg_data[hlcc_pkg::CW-1:0];
				hlcc_pkg::REG_ORIGIN_ROW:   orow_q <= cfg_data[hlcc_pkg::CW-1:0];
				hlcc_pkg::REG_CURSOR_Q:     curq_q <= cfg_data;
				hlcc_pkg::REG_CURSOR_R:     curr_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// size 0 acts as 1
	always_comb begin
		size_c = (size_q == 6'd0) ? 6'd1 : size_q;
		cfg.size = size_c;
		cfg.dvs = hlcc_pkg::DSW'(size_c) * 8'd3;
		cfg.border = border_q;
		cfg.ocol = ocol_q;
		cfg.orow = orow_q;
		cfg.cur_q = curq_q;
		cfg.cur_r = curr_q;
	end

	assign out_valid = vld_s[hlcc_pkg::TOTAL_STAGES-1];
	assign en = !(out_valid && out_stall);
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[hlcc_pkg::TOTAL_STAGES-2:0], in_valid};
		end
	end

	hlcc_front u_front (
		.clk      (clk),
		.en       (en),
		.cfg      (cfg),
		.cell_col (cell_col),
		.cell_row (cell_row),
		.side     (side_f),
		.dvq      (dvq),
		.dvr      (dvr)
	);

	hlcc_div u_div_q (
		.clk (clk),
		.en  (en),
		.dvd (dvq),
		.dvs (cfg.dvs),
		.quo (quo_q)
	);

	hlcc_div u_div_r (
		.clk (clk),
		.en  (en),
		.dvd (dvr),
		.dvs (cfg.dvs),
		.quo (quo_r)
	);

	// sideband rides alongside the divider
	always_ff @(posedge clk) begin
		if (en) begin
			sd_s[0] <= side_f;
		end
	end

	for (genvar i = 1; i < hlcc_pkg::DIV_STAGES; i++) begin : g_side
		always_ff @(posedge clk) begin
			if (en) begin
				sd_s[i] <= sd_s[i-1];
			end
		end
	end

	hlcc_back u_back (
		.clk        (clk),
		.en         (en),
		.cfg        (cfg),
		.side       (sd_s[hlcc_pkg::DIV_STAGES-1]),
		.quo_q      (quo_q),
		.quo_r      (quo_r),
		.is_edge    (is_edge),
		.glyph_code (glyph_code),
		.on_cursor  (on_cursor),
		.hex_q      (hex_q),
		.hex_r      (hex_r)
	);

	a_inside_dash: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_edge |-> glyph_code == hlcc_pkg::GLYPH_DASH)
		else $error("inside cell with non-dash glyph");

	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a held output word");

	a_chain_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> vld_s == $past(vld_s))
		else $error("valid chain moved during stall");

endmodule

[tb/hex_lattice_cell_classifier_tb.sv]
// Testbench for hex_lattice_cell_classifier: drives cells, predicts each
// classification word in fixed point and checks it in order.
// Depends on hlcc_pkg and the RTL of the classifier.
module hex_lattice_cell_classifier_tb;

	localparam logic [2:0] REG_SPARE_6 = 3'd6;
	localparam logic [2:0] REG_SPARE_7 = 3'd7;
	localparam int CYCLE_LIMIT = 600000;
	localparam int DRAIN_CYCLES = 50;
	localparam int HOLD_CYCLES = 400;

	typedef struct {
		logic               is_edge;
		hlcc_pkg::glyph_t   glyph;
		logic               on_cursor;
		logic [9:0]         hq;
		logic [9:0]         hr;
	} cell_class_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [2:0] cfg_index;
	logic [15:0] cfg_data;
	logic in_valid;
	logic in_stall;
	logic [hlcc_pkg::CW-1:0] cell_col;
	logic [hlcc_pkg::CW-1:0] cell_row;
	logic out_valid;
	logic out_stall;
	logic is_edge;
	logic [1:0] glyph_code;
	logic on_cursor;
	logic signed [hlcc_pkg::OW-1:0] hex_q;
	logic signed [hlcc_pkg::OW-1:0] hex_r;

	logic [5:0] sh_size;
	logic [7:0] sh_border;
	logic [9:0] sh_ocol;
	logic [9:0] sh_orow;
	logic [15:0] sh_cq;
	logic [15:0] sh_cr;

	cell_class_t pending_q[$];
	int errors = 0;
	int cells_sent = 0;
	int words_checked = 0;
	int edge_seen = 0;
	int cursor_seen = 0;
	longint cycles = 0;
	bit send_gaps = 1;
	bit recv_gaps = 1;
	bit hold_req = 0;
	bit hold_on = 0;

	hex_lattice_cell_classifier dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall),
		.cell_col(cell_col), .cell_row(cell_row), .out_valid(out_valid),
		.out_stall(out_stall), .is_edge(is_edge), .glyph_code(glyph_code),
		.on_cursor(on_cursor), .hex_q(hex_q), .hex_r(hex_r)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic longint rdiv(input longint n, input longint d);
		longint m;
		longint v;
		m = (n < 0) ? -n : n;
		v = (m + d / 2) / d;
		return (n < 0) ? -v : v;
	endfunction

	function automatic longint mag(input longint v);
		return (v < 0) ? -v : v;
	endfunction

	function automatic void classify(input logic [9:0] col, input logic [9:0] row,
			output cell_class_t res, output longint q, output longint r);
		longint one, size, px, py, den, fq, fr, fs, rq, rr, rs, dq, dr, ds;
		longint d, lim, dx, dy, cyq, a, b, bs, sq3, t22, t67;
		one = 65536;
		sq3 = longint'(hlcc_pkg::SQRT3_Q32);
		t22 = longint'(hlcc_pkg::TAN22_Q24);
		t67 = longint'(hlcc_pkg::TAN67_Q24);
		size = (sh_size == 0) ? 1 : longint'(sh_size);
		px = (longint'(col) - longint'(sh_ocol)) * 2;
		py = (longint'(row) - longint'(sh_orow)) * 4;
		den = 3 * size * one;
		fq = rdiv(2 * px * 64'sd4294967296, den);
		fr = rdiv(-px * 64'sd4294967296 + sq3 * py, den);
		fs = -fq - fr;
		rq = rdiv(fq, one);
		rr = rdiv(fr, one);
		rs = rdiv(fs, one);
		dq = mag(rq * one - fq);
		dr = mag(rr * one - fr);
		ds = mag(rs * one - fs);
		if (dq > dr && dq > ds) begin
			q = -rr - rs;
			r = rr;
		end else if (dr > ds) begin
			q = rq;
			r = -rq - rs;
		end else begin
			q = rq;
			r = rr;
		end
		d = mag(fq - q * one);
		if (mag(fr - r * one) > d) d = mag(fr - r * one);
		if (mag(fs - (-q - r) * one) > d) d = mag(fs - (-q - r) * one);
		lim = one / 2 - longint'(sh_border) * (one / 256);
		res.is_edge = (d >= lim);
		res.glyph = hlcc_pkg::GLYPH_DASH;
		if (res.is_edge) begin
			dx = px * one - 3 * size * q * (one / 2);
			cyq = rdiv(size * (q + 2 * r) * sq3, 64'sd131072);
			dy = py * one - cyq;
			a = mag(dx);
			b = mag(dy);
			bs = b * 64'sd16777216;
			if (bs <= a * t22) res.glyph = hlcc_pkg::GLYPH_BAR;
			else if (bs >= a * t67) res.glyph = hlcc_pkg::GLYPH_DASH;
			else if ((dx < 0) == (dy < 0)) res.glyph = hlcc_pkg::GLYPH_SLASH;
			else res.glyph = hlcc_pkg::GLYPH_BSLASH;
		end
		res.on_cursor = (q == longint'($signed(sh_cq))) && (r == longint'($signed(sh_cr)));
		res.hq = q[9:0];
		res.hr = r[9:0];
	endfunction

	task automatic report(input string what, input longint got, input longint want);
		errors++;
		$display("error at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
	endtask

	// long receiver hold-off, counted in cycles
	initial begin : hold_off
		int hold_left;
		bit hold_seen;
		hold_left = 0;
		hold_seen = 0;
		forever begin
			@(posedge clk);
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) hold_left--;
			hold_on <= (hold_left > 0);
		end
	end

	// checker and receiver stall control
	initial begin : receiver
		int burst_left;
		cell_class_t w;
		burst_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				if (pending_q.size() == 0) begin
					report("unexpected word, hex_q", hex_q, 0);
				end else begin
					w = pending_q.pop_front();
					words_checked++;
					if (w.is_edge) edge_seen++;
					if (w.on_cursor) cursor_seen++;
					if (is_edge !== w.is_edge) report("is_edge", is_edge, w.is_edge);
					if (glyph_code !== w.glyph) report("glyph_code", glyph_code, w.glyph);
					if (on_cursor !== w.on_cursor) report("on_cursor", on_cursor, w.on_cursor);
					if (hex_q !== w.hq) report("hex_q", hex_q, $signed(w.hq));
					if (hex_r !== w.hr) report("hex_r", hex_r, $signed(w.hr));
				end
			end
			if (burst_left > 0) burst_left--;
			else if (recv_gaps && $urandom_range(0, 9) == 0) burst_left = $urandom_range(1, 13);
			out_stall <= hold_on || (burst_left > 0);
		end
	end

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			hlcc_pkg::REG_HEX_SIZE: sh_size = data[5:0];
			hlcc_pkg::REG_BORDER_WIDTH: sh_border = data[7:0];
			hlcc_pkg::REG_ORIGIN_COL: sh_ocol = data[9:0];
			hlcc_pkg::REG_ORIGIN_ROW: sh_orow = data[9:0];
			hlcc_pkg::REG_CURSOR_Q: sh_cq = data;
			hlcc_pkg::REG_CURSOR_R: sh_cr = data;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic wait_idle();
		while (pending_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(input int size, input int border, input int ocol,
			input int orow, input int cq, input int cr);
		wait_idle();
		write_reg(hlcc_pkg::REG_HEX_SIZE, 16'(size));
		write_reg(hlcc_pkg::REG_BORDER_WIDTH, 16'(border));
		write_reg(hlcc_pkg::REG_ORIGIN_COL, 16'(ocol));
		write_reg(hlcc_pkg::REG_ORIGIN_ROW, 16'(orow));
		write_reg(hlcc_pkg::REG_CURSOR_Q, 16'(cq));
		write_reg(hlcc_pkg::REG_CURSOR_R, 16'(cr));
	endtask

	// point the cursor at the hex that holds the given cell
	task automatic aim_cursor(input logic [9:0] col, input logic [9:0] row);
		cell_class_t res;
		longint q, r;
		classify(col, row, res, q, r);
		write_reg(hlcc_pkg::REG_CURSOR_Q, 16'(q));
		write_reg(hlcc_pkg::REG_CURSOR_R, 16'(r));
	endtask

	task automatic send_cell(input logic [9:0] col, input logic [9:0] row);
		cell_class_t res;
		longint q, r;
		if (send_gaps && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		in_valid <= 1'b1;
		cell_col <= col;
		cell_row <= row;
		do @(posedge clk); while (!(in_valid && !in_stall));
		classify(col, row, res, q, r);
		pending_q.push_back(res);
		cells_sent++;
	endtask

	task automatic end_burst();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_random(input int n);
		repeat (n) send_cell(10'($urandom), 10'($urandom));
		end_burst();
	endtask

	task automatic random_config();
		int size, border;
		size = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 63) : $urandom_range(6, 40);
		border = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 128);
		set_config(size | ($urandom_range(0, 1023) << 6), border,
			$urandom_range(0, 1023), $urandom_range(0, 1023),
			$urandom_range(0, 65535), $urandom_range(0, 65535));
		aim_cursor(10'($urandom), 10'($urandom));
	endtask

	task automatic test_directed_extremes();
		send_cell(10'd0, 10'd0);
		send_cell(10'd1023, 10'd1023);
		send_cell(10'd0, 10'd1023);
		send_cell(10'd1023, 10'd0);
		send_cell(10'd7, 10'd3);
		end_burst();
		set_config(6, 0, 512, 512, 0, 0);
		send_cell(10'd0, 10'd0);
		send_cell(10'd1023, 10'd1023);
		send_cell(10'd512, 10'd512);
		send_cell(10'd515, 10'd512);
		send_cell(10'd512, 10'd514);
		send_cell(10'd509, 10'd510);
		end_burst();
	endtask

	task automatic test_config_extremes();
		// zero size acts as one; hexes run past the 10-bit field
		set_config(0, 128, 0, 0, 1364, -682);
		send_cell(10'd1023, 10'd0);
		send_cell(10'd1023, 10'd1023);
		send_cell(10'd0, 10'd0);
		end_burst();
		// border past half: everything is edge, centre gets bar
		set_config(63, 255, 300, 300, 0, 0);
		send_cell(10'd300, 10'd300);
		send_cell(10'd0, 10'd1023);
		send_cell(10'd1023, 10'd0);
		end_burst();
		set_config(40, 129, 1023, 1023, -32768, 32767);
		send_cell(10'd1023, 10'd1023);
		send_cell(10'd0, 10'd0);
		end_burst();
		wait_idle();
		write_reg(REG_SPARE_6, 16'hFFFF);
		write_reg(REG_SPARE_7, 16'h0005);
		send_cell(10'd40, 10'd900);
		end_burst();
	endtask

	task automatic test_cursor_hits();
		set_config(1, 26, 0, 0, 0, 0);
		aim_cursor(10'd1000, 10'd3);
		send_cell(10'd1000, 10'd3);
		send_cell(10'd1000, 10'd4);
		end_burst();
		set_config(14, 26, 800, 900, 0, 0);
		aim_cursor(10'd10, 10'd20);
		send_random(4);
		send_cell(10'd10, 10'd20);
		end_burst();
	endtask

	task automatic test_random_phases();
		repeat (7) begin
			random_config();
			send_gaps = $urandom_range(0, 3) != 0;
			recv_gaps = $urandom_range(0, 3) != 0;
			send_random(200);
		end
		send_gaps = 1;
		recv_gaps = 1;
	endtask

	task automatic test_backpressure();
		random_config();
		send_gaps = 0;
		@(posedge clk);
		hold_req = ~hold_req;
		send_random(250);
		send_gaps = 1;
	endtask

	task automatic test_quiet_tail();
		random_config();
		send_gaps = 0;
		recv_gaps = 0;
		send_random(250);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = hlcc_pkg::REG_HEX_SIZE;
		cfg_data = '0;
		in_valid = 1'b0;
		cell_col = '0;
		cell_row = '0;
		out_stall = 1'b0;
		sh_size = 6'd14;
		sh_border = 8'd26;
		sh_ocol = '0;
		sh_orow = '0;
		sh_cq = '0;
		sh_cr = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_extremes();
		test_config_extremes();
		test_cursor_hits();
		test_random_phases();
		test_backpressure();
		test_quiet_tail();
		wait_idle();
		$display("covered %0d cells, %0d words checked (%0d edge, %0d on cursor)",
			cells_sent, words_checked, edge_seen, cursor_seen);
		$display("config extremes, cursor hits, field wrap, long output hold-off");
		if (errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
